/* hw/rtl/amd_pkg.sv */
// Shared types, constants and helper functions for the adjacency-matrix
// depth-first walk block. Depends on nothing; every other file uses it.

package amd_pkg;

	localparam int NUM_VERTICES = 8;
	localparam int VERT_W = 3;
	localparam int IDX_W = $clog2(NUM_VERTICES);
	localparam int DEPTH_W = $clog2(NUM_VERTICES + 1);
	localparam int WEIGHT_W = 16;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_WALK = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [VERT_W-1:0]   vertex_a;
		logic [VERT_W-1:0]   vertex_b;
		logic [WEIGHT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic [VERT_W-1:0] visited_vertex;
		logic              last;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic edge_wr;
		logic walk_init;
		logic step;
		logic emit;
		logic emit_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_ok;
		logic cand_any;
		logic depth_one;
	} status_t;

	function automatic logic in_range(input logic [VERT_W-1:0] v);
		return int'(v) < NUM_VERTICES;
	endfunction

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [NUM_VERTICES-1:0] bits);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int k = NUM_VERTICES - 1; k >= 0; k--) begin
			if (bits[k]) begin
				idx = IDX_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

/* hw/rtl/adjacency_matrix_dfs.sv */
// Top level of the adjacency-matrix depth-first walk block.
// Depends on amd_pkg, amd_ctrl and amd_datapath.
//
//   channel   handshake               payload           transfer
//   -------   ---------------------   ---------------   ----------------------------
//   input     start, busy             item (item_t)     edge where start && !busy
//   result    strobe                  result (result_t) edge ending the strobe cycle
//
// A set-edge word leaves busy low, so another word can follow in the
// next cycle. A run word holds busy high while its walk runs: each step
// of the walk loop either pushes a neighbour or pops the stack, reading
// one matrix row and running one priority encoder.
// Each result word is registered from the step that decides it, so the
// final word (last set) is on the ports in the cycle where busy has just
// dropped. A run word whose start vertex is out of range leaves no result.
// Reset clears the matrix, the visited map and the stack depth at once.
// The receiver cannot stall; every strobed word is taken as it appears.

module adjacency_matrix_dfs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  amd_pkg::item_t   item,
	output logic             strobe,
	output amd_pkg::result_t result
);

	amd_pkg::cmd_t    cmd;
	amd_pkg::status_t status;

	// The controller sequences word acceptance and the walk loop.
	amd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath holds all graph and walk state and the result register.
	amd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.strobe (strobe),
		.result (result)
	);

	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("walk ended without a last word");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("last word while walk still running");

	a_edge_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == amd_pkg::KIND_EDGE |=> !busy && !strobe)
		else $error("set-edge word caused activity");

endmodule

/* hw/rtl/amd_ctrl.sv */
// Controller state machine of the depth-first walk block.
// Depends on amd_pkg for the state, command and status types.

module amd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             kind,
	input  amd_pkg::status_t status,
	output logic             busy,
	output amd_pkg::cmd_t    cmd
);

	amd_pkg::state_t state_q;
	amd_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			amd_pkg::ST_IDLE: begin
				if (start && kind == amd_pkg::KIND_WALK && status.start_ok) begin
					state_next = amd_pkg::ST_WALK;
				end
			end
			amd_pkg::ST_WALK: begin
				if (!status.cand_any && status.depth_one) begin
					state_next = amd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = amd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		cmd = '0;
		case (state_q)
			amd_pkg::ST_IDLE: begin
				cmd.edge_wr = start && kind == amd_pkg::KIND_EDGE;
				cmd.walk_init = start && kind == amd_pkg::KIND_WALK;
			end
			amd_pkg::ST_WALK: begin
				busy = 1'b1;
				cmd.step = 1'b1;
				// The held vertex goes out once its successor is known or the
				// stack is about to run empty.
				cmd.emit = status.cand_any || status.depth_one;
				cmd.emit_last = !status.cand_any;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* hw/rtl/amd_datapath.sv */
// Datapath of the depth-first walk block: adjacency matrix, visited map,
// walk stack, neighbor selection and the result register. Depends on amd_pkg.

module amd_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  amd_pkg::item_t   item,
	input  amd_pkg::cmd_t    cmd,
	output amd_pkg::status_t status,
	output logic             strobe,
	output amd_pkg::result_t result
);

	logic [amd_pkg::NUM_VERTICES-1:0] adj_q [amd_pkg::NUM_VERTICES];
	logic [amd_pkg::NUM_VERTICES-1:0] visited_q;
	logic [amd_pkg::IDX_W-1:0]        stack_q [amd_pkg::NUM_VERTICES];
	logic [amd_pkg::DEPTH_W-1:0]      depth_q;
	logic [amd_pkg::IDX_W-1:0]        pend_q;
	logic                             strobe_q;
	amd_pkg::result_t                 result_q;

	logic [amd_pkg::DEPTH_W-1:0]      depth_m1;
	logic [amd_pkg::IDX_W-1:0]        top_idx;
	logic [amd_pkg::IDX_W-1:0]        next_idx;
	logic [amd_pkg::IDX_W-1:0]        va_idx;
	logic [amd_pkg::IDX_W-1:0]        vb_idx;
	logic [amd_pkg::NUM_VERTICES-1:0] cand;
	logic                             edge_ok;
	logic                             edge_set;
	logic                             can_push;

	assign va_idx = amd_pkg::IDX_W'(item.vertex_a);
	assign vb_idx = amd_pkg::IDX_W'(item.vertex_b);
	assign edge_ok = amd_pkg::in_range(item.vertex_a) && amd_pkg::in_range(item.vertex_b);
	assign edge_set = item.weight != '0;

	assign depth_m1 = depth_q - amd_pkg::DEPTH_W'(1);
	assign top_idx = stack_q[depth_m1[amd_pkg::IDX_W-1:0]];
	assign cand = adj_q[top_idx] & ~visited_q;
	assign next_idx = amd_pkg::lowest_bit(cand);
	assign can_push = depth_q < amd_pkg::DEPTH_W'(amd_pkg::NUM_VERTICES);

	assign status.start_ok = amd_pkg::in_range(item.vertex_a);
	assign status.cand_any = |cand;
	assign status.depth_one = depth_q == amd_pkg::DEPTH_W'(1);

	// Both directions of an edge are written together. A self loop touches
	// only the one diagonal bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amd_pkg::NUM_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.edge_wr && edge_ok) begin
			adj_q[va_idx][vb_idx] <= edge_set;
			if (vb_idx != va_idx) begin
				adj_q[vb_idx][va_idx] <= edge_set;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.walk_init) begin
				if (status.start_ok) begin
					visited_q <= amd_pkg::NUM_VERTICES'(1) << va_idx;
					depth_q <= amd_pkg::DEPTH_W'(1);
				end else begin
					visited_q <= '0;
					depth_q <= '0;
				end
			end else if (cmd.step) begin
				if (status.cand_any) begin
					visited_q <= visited_q | (amd_pkg::NUM_VERTICES'(1) << next_idx);
					if (can_push) begin
						depth_q <= depth_q + amd_pkg::DEPTH_W'(1);
					end
				end else begin
					depth_q <= depth_m1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			stack_q[0] <= va_idx;
			pend_q <= va_idx;
		end else if (cmd.step && status.cand_any) begin
			if (can_push) begin
				stack_q[depth_q[amd_pkg::IDX_W-1:0]] <= next_idx;
			end
			pend_q <= next_idx;
		end
		if (cmd.emit) begin
			result_q.visited_vertex <= amd_pkg::VERT_W'(pend_q);
			result_q.last <= cmd.emit_last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= amd_pkg::DEPTH_W'(amd_pkg::NUM_VERTICES))
		else $error("walk stack depth beyond vertex count");

	a_init_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_init && status.start_ok |=> depth_q == amd_pkg::DEPTH_W'(1)
		&& $onehot(visited_q))
		else $error("walk did not start with one stacked, visited vertex");

	a_visit_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.cand_any |=>
		$countones(visited_q) == $countones($past(visited_q)) + 1)
		else $error("taken neighbor was already visited");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> depth_q == '0)
		else $error("last word sent while stack still holds vertices");

endmodule
